// ===== src/rpsk_pkg.sv =====
// Shared types, widths and metric codes for the RGB pixel sort key block.
package rpsk_pkg;

	localparam int unsigned COMP_W         = 8;
	localparam int unsigned KEY_W          = 8;
	localparam int unsigned METRIC_W       = 4;
	localparam int unsigned NUM_W          = 19;
	localparam int unsigned DEN_W          = 11;
	localparam int unsigned DIV_STAGES     = 4;
	localparam int unsigned BITS_PER_STAGE = KEY_W / DIV_STAGES;

	typedef enum logic [METRIC_W-1:0] {
		METRIC_RED       = 4'd0,
		METRIC_GREEN     = 4'd1,
		METRIC_BLUE      = 4'd2,
		METRIC_AVERAGE   = 4'd3,
		METRIC_MAX       = 4'd4,
		METRIC_MIN       = 4'd5,
		METRIC_CHROMA    = 4'd6,
		METRIC_LIGHTNESS = 4'd7,
		METRIC_HUE       = 4'd8,
		METRIC_SAT_HSV   = 4'd9,
		METRIC_SAT_HSL   = 4'd10
	} metric_t;

	// Partial state of the restoring divider.
	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [KEY_W-1:0] quo;
	} div_item_t;

	// One restoring step for quotient bit k.
	function automatic div_item_t div_step(input div_item_t it, input int unsigned k);
		div_item_t      res;
		logic [NUM_W:0] shifted;
		logic [NUM_W:0] trial;
		res     = it;
		shifted = {{(NUM_W+1-DEN_W){1'b0}}, it.den} << k;
		trial   = {1'b0, it.rem} - shifted;
		if (!trial[NUM_W]) begin
			res.rem = trial[NUM_W-1:0];
			res.quo = it.quo | (KEY_W'(1) << k);
		end
		return res;
	endfunction

endpackage

// ===== src/rpsk_div_stage.sv =====
// One registered stage of the pipelined restoring divider.
module rpsk_div_stage
	import rpsk_pkg::*;
#(
	parameter int unsigned STAGE = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output div_item_t out_item
);

	div_item_t nxt;
	logic      valid_q;
	div_item_t item_q;

	always_comb begin
		nxt = in_item;
		for (int unsigned i = 0; i < BITS_PER_STAGE; i++) begin
			nxt = div_step(nxt, KEY_W - 1 - STAGE * BITS_PER_STAGE - i);
		end
	end

	// advance when empty or when the next stage takes the held request
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

// ===== src/rgb_pixel_sort_key_top.sv =====
// Top level of the RGB pixel sort key block: stream in, stream out, one metric register.
//
// Each request on the slave stream carries one RGB pixel of 8-bit components and produces exactly one
// 8-bit sort key on the master stream, in order. The key is picked by the metric register:
// red, green, blue, average, max (HSV value), min, chroma, HSL lightness, hue (360 degrees
// scaled to 255), HSV saturation or HSL saturation; codes 11..15 give zero. Every key is the
// exact rational value truncated toward zero. Throughput is one pixel per clock while m_axis_tready
// is high. Three stages compute max/min, hue sector and the dividend/divisor pair, then four
// stages of a restoring divider resolve two quotient bits each. Every metric, including the plain
// ones, passes through the divider (plain metrics use a divisor of one). Each stage holds its own
// valid bit and advances when empty or drained, so bubbles collapse and backpressure loses nothing.
// Write the metric only while the pipeline is empty; cfg_ready is always high.
module rgb_pixel_sort_key_top
	import rpsk_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// configuration write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [METRIC_W-1:0] cfg_data,      // metric code
	// pixel stream in
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [23:0]         s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
	// key stream out
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [KEY_W-1:0]    m_axis_tdata   // sort_key [7:0]
);

	logic [METRIC_W-1:0] metric_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= METRIC_RED;
		end else if (cfg_valid && cfg_ready) begin
			metric_q <= cfg_data;
		end
	end

	// ---------------- stage 1: max, min, chroma, sum, sector ----------------
	logic [COMP_W-1:0] r_in, g_in, b_in;
	logic [COMP_W-1:0] mx_in, mn_in;
	logic              rmax_in, gmax_in;

	assign r_in = s_axis_tdata[7:0];
	assign g_in = s_axis_tdata[15:8];
	assign b_in = s_axis_tdata[23:16];

	always_comb begin
		// ties go to red first, then green
		rmax_in = (r_in >= g_in) && (r_in >= b_in);
		gmax_in = !rmax_in && (g_in >= b_in);
		mx_in   = rmax_in ? r_in : (gmax_in ? g_in : b_in);
		if (r_in <= g_in && r_in <= b_in) begin
			mn_in = r_in;
		end else if (g_in <= b_in) begin
			mn_in = g_in;
		end else begin
			mn_in = b_in;
		end
	end

	logic              v_s1;
	logic              adv_s1, adv_s2, adv_s3;
	logic [COMP_W-1:0] r_s1, g_s1, b_s1, mx_s1, mn_s1, c_s1;
	logic [COMP_W:0]   sum_s1;
	logic              rmax_s1, gmax_s1;

	assign s_axis_tready = adv_s1;
	assign adv_s1        = !v_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			r_s1    <= r_in;
			g_s1    <= g_in;
			b_s1    <= b_in;
			mx_s1   <= mx_in;
			mn_s1   <= mn_in;
			c_s1    <= mx_in - mn_in;
			sum_s1  <= {1'b0, mx_in} + {1'b0, mn_in};
			rmax_s1 <= rmax_in;
			gmax_s1 <= gmax_in;
		end
	end

	// ---------------- stage 2: hue offset, six chroma, HSL divisor ----------------
	logic [DEN_W-1:0] six_c, h_nxt;
	logic [COMP_W:0]  d_nxt;

	always_comb begin
		six_c = (DEN_W'(c_s1) << 2) + (DEN_W'(c_s1) << 1);
		// modulo-2^11 arithmetic; every sector result lands in [0, 6c)
		if (rmax_s1) begin
			if (g_s1 >= b_s1) begin
				h_nxt = DEN_W'(g_s1) - DEN_W'(b_s1);
			end else begin
				h_nxt = six_c - (DEN_W'(b_s1) - DEN_W'(g_s1));
			end
		end else if (gmax_s1) begin
			h_nxt = (DEN_W'(c_s1) << 1) + DEN_W'(b_s1) - DEN_W'(r_s1);
		end else begin
			h_nxt = (DEN_W'(c_s1) << 2) + DEN_W'(r_s1) - DEN_W'(g_s1);
		end
		// mirror the sum about the middle grey when lightness is above half
		d_nxt = (sum_s1 <= (COMP_W+1)'(255)) ? sum_s1 : (COMP_W+1)'(510) - sum_s1;
	end

	logic              v_s2;
	logic [COMP_W-1:0] r_s2, g_s2, b_s2, mx_s2, mn_s2, c_s2;
	logic [COMP_W:0]   sum_s2, d_s2;
	logic [DEN_W-1:0]  six_c_s2, h_s2;
	logic [9:0]        rgb_sum_s2;

	assign adv_s2 = !v_s2 || adv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			r_s2       <= r_s1;
			g_s2       <= g_s1;
			b_s2       <= b_s1;
			mx_s2      <= mx_s1;
			mn_s2      <= mn_s1;
			c_s2       <= c_s1;
			sum_s2     <= sum_s1;
			d_s2       <= d_nxt;
			six_c_s2   <= six_c;
			h_s2       <= h_nxt;
			rgb_sum_s2 <= 10'(r_s1) + 10'(g_s1) + 10'(b_s1);
		end
	end

	// ---------------- stage 3: dividend and divisor per metric ----------------
	localparam logic [DEN_W-1:0] DEN_ONE = DEN_W'(1);

	logic [NUM_W-1:0] c255, h255;
	div_item_t        item_nxt;

	always_comb begin
		// times 255 as times 256 minus one copy
		c255 = (NUM_W'(c_s2) << 8) - NUM_W'(c_s2);
		h255 = (NUM_W'(h_s2) << 8) - NUM_W'(h_s2);
		item_nxt.quo = '0;
		item_nxt.rem = '0;
		item_nxt.den = DEN_ONE;
		unique case (metric_q)
			METRIC_RED:       item_nxt.rem = NUM_W'(r_s2);
			METRIC_GREEN:     item_nxt.rem = NUM_W'(g_s2);
			METRIC_BLUE:      item_nxt.rem = NUM_W'(b_s2);
			METRIC_AVERAGE: begin
				item_nxt.rem = NUM_W'(rgb_sum_s2);
				item_nxt.den = DEN_W'(3);
			end
			METRIC_MAX:       item_nxt.rem = NUM_W'(mx_s2);
			METRIC_MIN:       item_nxt.rem = NUM_W'(mn_s2);
			METRIC_CHROMA:    item_nxt.rem = NUM_W'(c_s2);
			METRIC_LIGHTNESS: begin
				item_nxt.rem = NUM_W'(sum_s2);
				item_nxt.den = DEN_W'(2);
			end
			METRIC_HUE: begin
				// grey pixel keeps zero over one
				if (c_s2 != '0) begin
					item_nxt.rem = h255;
					item_nxt.den = six_c_s2;
				end
			end
			METRIC_SAT_HSV: begin
				// black pixel keeps zero over one
				if (mx_s2 != '0) begin
					item_nxt.rem = c255;
					item_nxt.den = DEN_W'(mx_s2);
				end
			end
			METRIC_SAT_HSL: begin
				// black or white keeps zero over one
				if (d_s2 != '0) begin
					item_nxt.rem = c255;
					item_nxt.den = DEN_W'(d_s2);
				end
			end
			default: begin
				item_nxt.rem = '0;
			end
		endcase
	end

	logic      v_s3;
	div_item_t item_s3;

	logic      dv_valid [DIV_STAGES+1];
	logic      dv_ready [DIV_STAGES+1];
	div_item_t dv_item  [DIV_STAGES+1];

	assign adv_s3 = !v_s3 || dv_ready[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			item_s3 <= item_nxt;
		end
	end

	// ---------------- stages 4..7: restoring divider, two bits per stage ----------------
	assign dv_valid[0] = v_s3;
	assign dv_item[0]  = item_s3;

	for (genvar gi = 0; gi < DIV_STAGES; gi++) begin : g_div
		rpsk_div_stage #(
			.STAGE (gi)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv_valid[gi]),
			.in_ready  (dv_ready[gi]),
			.in_item   (dv_item[gi]),
			.out_valid (dv_valid[gi+1]),
			.out_ready (dv_ready[gi+1]),
			.out_item  (dv_item[gi+1])
		);
	end

	// the last divider stage doubles as the output register
	assign dv_ready[DIV_STAGES] = m_axis_tready;
	assign m_axis_tvalid        = dv_valid[DIV_STAGES];
	assign m_axis_tdata         = dv_item[DIV_STAGES].quo;

endmodule
